FILE: rtl/sce_pkg.sv
package sce_pkg;

  // Largest module the scanner walks; words beyond it count as overrun.
  localparam int unsigned MAX_MODULE_WORDS = 65536;
  localparam int unsigned IDX_W = $clog2(MAX_MODULE_WORDS + 1);
  localparam int unsigned LEN_W = 16;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned SUM_W = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;

  localparam logic [31:0] SPV_MAGIC = 32'h0723_0203;
  localparam int unsigned HEADER_WORDS = 5;
  localparam logic [15:0] OP_ENTRY_POINT = 16'd15;
  localparam logic [31:0] MODEL_GLCOMPUTE = 32'd5;
  localparam int unsigned MIN_ENTRY_WORDS = 4;
  localparam int unsigned NAME_FIRST_WORD = 3;

  typedef enum logic [2:0] {
    ST_FOUND        = 3'd0,
    ST_BAD_HEADER   = 3'd1,
    ST_ZERO_SIZE    = 3'd2,
    ST_OVERRUN      = 3'd3,
    ST_UNTERMINATED = 3'd4,
    ST_NONE         = 3'd5
  } scan_status_e;

  // Outcome of a module, valid on its final word.
  typedef struct packed {
    scan_status_e          status;
    logic [OFFSET_W-1:0]   offset;
  } sce_result_t;

  // One accepted word as seen by the scanner.
  typedef struct packed {
    logic        accept;
    logic        final_word;
    logic [31:0] data;
  } sce_word_t;

  function automatic logic has_zero_byte(input logic [31:0] w);
    return (w[7:0] == 8'h00) || (w[15:8] == 8'h00) ||
           (w[23:16] == 8'h00) || (w[31:24] == 8'h00);
  endfunction

endpackage

FILE: rtl/spirv_compute_entry_finder.sv
// Compute entry point scanner for a SPIR-V module.
//
// Input channel: one 32-bit module word per handshake (in_valid_i / in_stall_o),
// with final_word_i high on the module's last word. A word is taken at a clock
// edge where in_valid_i is high and in_stall_o is low.
// Output channel: one result per module (out_valid_o / out_stall_i), carrying
// scan_status_o and name_word_offset_o, produced only for the final word.
//
// Throughput: one word per cycle while in_stall_o is low. Each word passes
// through a single stage of compare and counter logic that updates the scan
// state directly. Result: out_valid_o rises in the cycle after the final word
// is taken, from a single result register.
//
// Stall: while a result is held and out_stall_i is high, in_stall_o rises and no
// word is taken; in every other cycle a word may enter, even while the result
// register is being drained in that same cycle.
//
// Reset (rst_ni low, asynchronous) empties the result register and puts the
// scanner at word 0 of a fresh module. After each final word the scanner
// returns to that same state, ready for the next module.
module spirv_compute_entry_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] module_word_i,
  input  logic        final_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  scan_status_o,
  output logic [15:0] name_word_offset_o
);
  import sce_pkg::*;

  sce_word_t   word;
  sce_result_t result;
  logic        accept;

  logic                out_valid_q;
  scan_status_e        status_q;
  logic [OFFSET_W-1:0] offset_q;

  // Hold input only while a result waits and the receiver stalls
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign word.accept     = accept;
  assign word.final_word = final_word_i;
  assign word.data       = module_word_i;

  sce_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .word_i   (word),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && final_word_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the outcome on the final word; hold it otherwise
  always_ff @(posedge clk_i) begin
    if (accept && final_word_i) begin
      status_q <= result.status;
      offset_q <= result.offset;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign scan_status_o      = status_q;
  assign name_word_offset_o = offset_q;

endmodule

FILE: rtl/sce_scan.sv
module sce_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sce_pkg::sce_word_t   word_i,
  output sce_pkg::sce_result_t result_o
);
  import sce_pkg::*;

  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [IDX_W-1:0]    start_q, start_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic                cand_q, cand_d;
  logic                term_q, term_d;
  logic                dec_q, dec_d;
  scan_status_e        lstat_q, lstat_d;
  logic [OFFSET_W-1:0] loff_q, loff_d;

  logic [IDX_W-1:0]    rel;
  logic [LEN_W-1:0]    op_code;
  logic [LEN_W-1:0]    op_size;
  logic [SUM_W-1:0]    end_sum;
  logic [SUM_W-1:0]    next_idx;
  logic [IDX_W:0]      idx_plus1;
  logic [IDX_W:0]      start_ext;
  logic [OFFSET_W-1:0] name_off;
  scan_status_e        fin_status;

  assign rel       = idx_q - start_q;
  assign op_code   = word_i.data[15:0];
  assign op_size   = word_i.data[31:16];
  assign next_idx  = SUM_W'(idx_q) + SUM_W'(1);
  assign name_off  = OFFSET_W'(SUM_W'(start_q) + SUM_W'(NAME_FIRST_WORD));

  always_comb begin
    idx_d   = idx_q;
    start_d = start_q;
    len_d   = len_q;
    cand_d  = cand_q;
    term_d  = term_q;
    dec_d   = dec_q;
    lstat_d = lstat_q;
    loff_d  = loff_q;
    end_sum = '0;

    if (!dec_q) begin
      if (idx_q >= IDX_W'(MAX_MODULE_WORDS)) begin
        dec_d   = 1'b1;
        lstat_d = ST_OVERRUN;
        loff_d  = '0;
      end else if (idx_q == '0) begin
        if (word_i.data != SPV_MAGIC) begin
          dec_d   = 1'b1;
          lstat_d = ST_BAD_HEADER;
          loff_d  = '0;
        end
      end else if (idx_q >= IDX_W'(HEADER_WORDS)) begin
        if (idx_q == start_q) begin
          // Opcode word: open a new instruction
          if (op_size == '0) begin
            dec_d   = 1'b1;
            lstat_d = ST_ZERO_SIZE;
            loff_d  = '0;
          end else begin
            len_d  = op_size;
            cand_d = (op_code == OP_ENTRY_POINT) && (op_size >= LEN_W'(MIN_ENTRY_WORDS));
            term_d = 1'b0;
          end
        end else if (cand_q) begin
          if (rel == IDX_W'(1)) begin
            if (word_i.data != MODEL_GLCOMPUTE) cand_d = 1'b0;
          end else if (rel >= IDX_W'(NAME_FIRST_WORD) && has_zero_byte(word_i.data)) begin
            term_d = 1'b1;
          end
        end

        end_sum = SUM_W'(start_q) + SUM_W'(len_d);
        if (!dec_d && end_sum == next_idx) begin
          // Last word of the instruction: decide on a candidate, advance
          if (cand_d) begin
            dec_d   = 1'b1;
            lstat_d = term_d ? ST_FOUND : ST_UNTERMINATED;
            loff_d  = term_d ? name_off : '0;
          end
          start_d = IDX_W'(end_sum);
          cand_d  = 1'b0;
          term_d  = 1'b0;
        end
      end
    end

    if (idx_q < IDX_W'(MAX_MODULE_WORDS)) idx_d = IDX_W'(next_idx);
  end

  assign idx_plus1 = (IDX_W + 1)'(idx_q) + (IDX_W + 1)'(1);
  assign start_ext = (IDX_W + 1)'(start_d);

  always_comb begin
    if (dec_d) begin
      fin_status = lstat_d;
    end else if (idx_plus1 < (IDX_W + 1)'(HEADER_WORDS)) begin
      fin_status = ST_BAD_HEADER;
    end else if (start_ext == idx_plus1) begin
      fin_status = ST_NONE;
    end else begin
      fin_status = ST_OVERRUN;
    end
  end

  assign result_o.status = fin_status;
  assign result_o.offset = (fin_status == ST_FOUND) ? loff_d : '0;

  // Advance on each accepted word; return to the idle state after the final one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      start_q <= IDX_W'(HEADER_WORDS);
      len_q   <= '0;
      cand_q  <= 1'b0;
      term_q  <= 1'b0;
      dec_q   <= 1'b0;
      lstat_q <= ST_NONE;
      loff_q  <= '0;
    end else if (word_i.accept) begin
      if (word_i.final_word) begin
        idx_q   <= '0;
        start_q <= IDX_W'(HEADER_WORDS);
        len_q   <= '0;
        cand_q  <= 1'b0;
        term_q  <= 1'b0;
        dec_q   <= 1'b0;
        lstat_q <= ST_NONE;
        loff_q  <= '0;
      end else begin
        idx_q   <= idx_d;
        start_q <= start_d;
        len_q   <= len_d;
        cand_q  <= cand_d;
        term_q  <= term_d;
        dec_q   <= dec_d;
        lstat_q <= lstat_d;
        loff_q  <= loff_d;
      end
    end
  end

endmodule

FILE: tb/sv/entry_scan_tb_pkg.sv
package entry_scan_tb_pkg;
  import sce_pkg::*;

  // Tracks the scan of the module being streamed and keeps the outcomes still owed.
  class entry_scan_scoreboard;
    logic [16:0]  word_idx;
    logic [16:0]  ins_start;
    logic [15:0]  ins_len;
    bit           in_entry;
    bit           name_ended;
    bit           decided;
    scan_status_e held_status;
    logic [15:0]  held_offset;

    sce_result_t  pending_outcomes[$];
    int unsigned  errors;
    int unsigned  outcomes_checked;
    int unsigned  status_count[6];

    function new();
      errors = 0;
      outcomes_checked = 0;
      foreach (status_count[i]) status_count[i] = 0;
      restart();
    endfunction

    function void restart();
      word_idx    = '0;
      ins_start   = 17'(HEADER_WORDS);
      ins_len     = '0;
      in_entry    = 1'b0;
      name_ended  = 1'b0;
      decided     = 1'b0;
      held_status = ST_NONE;
      held_offset = '0;
    endfunction

    function void settle(scan_status_e st, logic [15:0] off);
      decided     = 1'b1;
      held_status = st;
      held_offset = off;
    endfunction

    function bit word_has_nul(logic [31:0] w);
      for (int b = 0; b < 4; b++)
        if (w[8*b +: 8] == 8'h00) return 1'b1;
      return 1'b0;
    endfunction

    // Advance the scan by one accepted word; queue the outcome on the final word.
    function void take_word(logic [31:0] w, logic fin);
      logic [16:0] idx;
      logic [16:0] rel;
      logic [17:0] end_idx;
      sce_result_t outcome;
      idx = word_idx;
      if (!decided) begin
        if (idx >= MAX_MODULE_WORDS) begin
          settle(ST_OVERRUN, '0);
        end else if (idx == 0) begin
          if (w != SPV_MAGIC) settle(ST_BAD_HEADER, '0);
        end else if (idx >= HEADER_WORDS) begin
          if (idx == ins_start) begin
            if (w[31:16] == 16'h0000) begin
              settle(ST_ZERO_SIZE, '0);
            end else begin
              ins_len    = w[31:16];
              in_entry   = (w[15:0] == OP_ENTRY_POINT) && (w[31:16] >= MIN_ENTRY_WORDS);
              name_ended = 1'b0;
            end
          end else if (in_entry) begin
            rel = idx - ins_start;
            if (rel == 1) begin
              if (w != MODEL_GLCOMPUTE) in_entry = 1'b0;
            end else if (rel >= NAME_FIRST_WORD && word_has_nul(w)) begin
              name_ended = 1'b1;
            end
          end
          end_idx = {1'b0, ins_start} + {2'b00, ins_len} - 18'd1;
          if (!decided && {1'b0, idx} == end_idx) begin
            if (in_entry) begin
              if (name_ended) settle(ST_FOUND, 16'(ins_start + NAME_FIRST_WORD));
              else settle(ST_UNTERMINATED, '0);
            end
            ins_start  = ins_start + ins_len;
            in_entry   = 1'b0;
            name_ended = 1'b0;
          end
        end
      end
      if (word_idx < MAX_MODULE_WORDS) word_idx = word_idx + 1'b1;
      if (fin) begin
        outcome.offset = '0;
        if (decided) begin
          outcome.status = held_status;
          outcome.offset = held_offset;
        end else if (idx + 1 < HEADER_WORDS) begin
          outcome.status = ST_BAD_HEADER;
        end else if (ins_start == idx + 1) begin
          outcome.status = ST_NONE;
        end else begin
          outcome.status = ST_OVERRUN;
        end
        if (outcome.status != ST_FOUND) outcome.offset = '0;
        pending_outcomes.push_back(outcome);
        restart();
      end
    endfunction

    function void check_outcome(logic [2:0] st, logic [15:0] off);
      sce_result_t want;
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected outcome: expected none, got status %0d offset %0d",
                 $time, st, off);
        return;
      end
      want = pending_outcomes.pop_front();
      outcomes_checked++;
      status_count[int'(want.status)]++;
      if (st !== want.status) begin
        errors++;
        $display("%0t: scan_status mismatch: expected %0d, got %0d", $time, want.status, st);
      end
      if (off !== want.offset) begin
        errors++;
        $display("%0t: name_word_offset mismatch: expected %0d, got %0d",
                 $time, want.offset, off);
      end
    endfunction

    function void flag_leftovers();
      sce_result_t want;
      while (pending_outcomes.size() != 0) begin
        want = pending_outcomes.pop_front();
        errors++;
        $display("%0t: missing outcome: expected status %0d offset %0d, got nothing",
                 $time, want.status, want.offset);
      end
    endfunction

    function int unsigned pending();
      return pending_outcomes.size();
    endfunction
  endclass

endpackage

FILE: tb/sv/spirv_compute_entry_finder_tb.sv
module spirv_compute_entry_finder_tb;
  import sce_pkg::*;
  import entry_scan_tb_pkg::*;

  // Guard far above the slowest legal run (the heavily idled phases dominate).
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned PHASE_WORDS = 472;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [31:0] module_word_i = '0;
  logic        final_word_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [2:0]  scan_status_o;
  logic [15:0] name_word_offset_o;

  entry_scan_scoreboard sb;

  // Module under construction, streamed by send_module.
  logic [31:0] mod_words[$];
  int unsigned words_sent   = 0;
  int unsigned modules_sent = 0;
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned cycle_count  = 0;

  spirv_compute_entry_finder uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .module_word_i      (module_word_i),
    .final_word_i       (final_word_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .scan_status_o      (scan_status_o),
    .name_word_offset_o (name_word_offset_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abandon the run if it hangs; count every edge.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: stall at random at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_idle_pct);
  end

  // Monitor both handshakes on the values held just before the edge, as the
  // block itself sees them. Feed every accepted word to the scoreboard and
  // check every accepted outcome against the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.take_word(module_word_i, final_word_i);
      if (out_valid_o && !out_stall_i) sb.check_outcome(scan_status_o, name_word_offset_o);
    end
  end

  // Offer one word, idling first at random; hold it until accepted.
  task automatic send_word(input logic [31:0] w, input logic fin);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    module_word_i <= w;
    final_word_i  <= fin;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stream the queued module, flagging its last word, then clear the queue.
  task automatic send_module();
    foreach (mod_words[i]) send_word(mod_words[i], i == mod_words.size() - 1);
    words_sent   += mod_words.size();
    modules_sent += 1;
    mod_words.delete();
  endtask

  // Drop valid and hold off until every owed outcome has been drained.
  task automatic wait_for_outcomes();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Header: magic (or a corrupted one) plus four words of any content.
  task automatic put_header(input bit good);
    logic [31:0] magic;
    magic = SPV_MAGIC;
    if (!good) begin
      if ($urandom_range(1)) magic = SPV_MAGIC ^ (32'd1 << $urandom_range(31));
      else magic = $urandom();
      if (magic == SPV_MAGIC) magic = ~SPV_MAGIC;
    end
    mod_words.push_back(magic);
    repeat (4) mod_words.push_back($urandom());
  endtask

  // Any instruction that is not an entry point.
  task automatic put_filler();
    logic [15:0] sz;
    logic [15:0] op;
    sz = 16'($urandom_range(1, 6));
    op = 16'($urandom_range(0, 65535));
    if (op == OP_ENTRY_POINT) op = op + 1'b1;
    mod_words.push_back({sz, op});
    repeat (sz - 1) mod_words.push_back($urandom());
  endtask

  // Entry point with a name of one or more words. A terminated name gets at
  // least one NUL byte somewhere; an unterminated one has none at all.
  task automatic put_entry(input bit compute, input bit terminated);
    logic [15:0] sz;
    logic [31:0] model;
    logic [31:0] w;
    int unsigned nul_at;
    sz = ($urandom_range(9) == 0) ? 16'($urandom_range(9, 20)) : 16'($urandom_range(4, 8));
    mod_words.push_back({sz, OP_ENTRY_POINT});
    if (compute) begin
      model = MODEL_GLCOMPUTE;
    end else begin
      case ($urandom_range(2))
        0:       model = 32'($urandom_range(0, 6));
        1:       model = $urandom();
        default: model = MODEL_GLCOMPUTE ^ (32'd1 << $urandom_range(31));
      endcase
      if (model == MODEL_GLCOMPUTE) model = 32'd6;
    end
    mod_words.push_back(model);
    mod_words.push_back($urandom());
    nul_at = $urandom_range(0, sz - 4);
    for (int k = 0; k <= sz - 4; k++) begin
      for (int b = 0; b < 4; b++) w[8*b +: 8] = 8'($urandom_range(1, 255));
      if (terminated && (k == nul_at || $urandom_range(3) == 0))
        w[8*$urandom_range(3) +: 8] = 8'h00;
      mod_words.push_back(w);
    end
  endtask

  // Entry point too short to count, even with the compute model and a NUL.
  task automatic put_short_entry();
    logic [15:0] sz;
    sz = 16'($urandom_range(1, 3));
    mod_words.push_back({sz, OP_ENTRY_POINT});
    if (sz >= 2) mod_words.push_back(MODEL_GLCOMPUTE);
    if (sz == 3) mod_words.push_back(32'h0000_0000);
  endtask

  // Mostly well-formed modules with random content; some noise, short and
  // broken modules on top.
  task automatic build_random_module();
    int unsigned kind;
    int unsigned n;
    int unsigned r;
    logic [15:0] sz;
    kind = $urandom_range(99);
    if (kind < 6) begin
      n = $urandom_range(1, 12);
      repeat (n) mod_words.push_back($urandom());
      if ($urandom_range(1)) mod_words[0] = SPV_MAGIC;
    end else if (kind < 10) begin
      n = $urandom_range(1, 4);
      mod_words.push_back(SPV_MAGIC);
      repeat (n - 1) mod_words.push_back($urandom());
    end else begin
      put_header($urandom_range(19) != 0);
      n = $urandom_range(0, 5);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 40) put_filler();
        else if (r < 50) put_entry(1'b0, $urandom_range(1));
        else if (r < 55) put_short_entry();
        else if (r < 93) put_entry(1'b1, $urandom_range(3) != 0);
        else mod_words.push_back({16'h0000, 16'($urandom_range(0, 65535))});
      end
      r = $urandom_range(99);
      if (r >= 80) begin
        // Trim the tail so the last word may fall inside an instruction.
        n = $urandom_range(1, 3);
        while (n > 0 && mod_words.size() > 5) begin
          void'(mod_words.pop_back());
          n--;
        end
      end else if (r >= 70) begin
        // Start one more instruction and end the module part-way through it.
        sz = 16'($urandom_range(2, 6));
        mod_words.push_back({sz, 16'($urandom_range(0, 65535))});
        repeat ($urandom_range(0, sz - 2)) mod_words.push_back($urandom());
      end
    end
  endtask

  initial begin
    int unsigned phase_start;
    bit          held_off;
    held_off     = 1'b0;
    sb           = new();
    in_idle_pct  = 27;
    out_idle_pct = 85;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed modules: lone bad magic, short module, header only,
    // zero-size instruction followed by an ignored word, overrun, and a
    // compute entry whose last name word carries the NUL.
    mod_words = '{32'h0000_0000};
    send_module();
    mod_words = '{SPV_MAGIC, 32'hFFFF_FFFF};
    send_module();
    mod_words = '{SPV_MAGIC, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF};
    send_module();
    mod_words = '{SPV_MAGIC, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF, 32'h0004_000F};
    send_module();
    mod_words = '{SPV_MAGIC, 32'h1, 32'h2, 32'h3, 32'h4, 32'h0003_FFFF};
    send_module();
    mod_words = '{SPV_MAGIC, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h0004_000F, MODEL_GLCOMPUTE, 32'hFFFF_FFFF, 32'h4142_4300};
    send_module();

    // Random modules under three idling mixes; pause once mid-way in the
    // first until the block has nothing left to deliver.
    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 27 : (phase == 1) ? 85 : 0;
      out_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 27 : 0;
      phase_start  = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        build_random_module();
        send_module();
        if (phase == 0 && !held_off && words_sent - phase_start > PHASE_WORDS / 2) begin
          wait_for_outcomes();
          held_off = 1'b1;
        end
      end
    end

    wait_for_outcomes();
    repeat (4) @(posedge clk_i);
    sb.flag_leftovers();

    $display("covered %0d modules, %0d words, directed corner modules and three idling mixes",
             modules_sent, words_sent);
    $display("outcomes: found %0d, bad header %0d, zero size %0d, overrun %0d,",
             sb.status_count[ST_FOUND], sb.status_count[ST_BAD_HEADER],
             sb.status_count[ST_ZERO_SIZE], sb.status_count[ST_OVERRUN]);
    $display("          unterminated %0d, none %0d",
             sb.status_count[ST_UNTERMINATED], sb.status_count[ST_NONE]);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
